// ----- src/aesh_pkg.sv -----
package aesh_pkg;

  localparam int unsigned LaneCount = 4;
  localparam int unsigned LaneWidth = 128;
  localparam int unsigned BlockWidth = LaneCount * LaneWidth;

  // lane i occupies bits [128i +: 128]; within a lane the low word is message bytes 0..7
  localparam logic [BlockWidth-1:0] InitState = {
    64'h7e99494879a10005, 64'h07ad828d630a240c,
    64'he8a07ce45079506b, 64'hae62c7d06a770017,
    64'hace78057f59e125a, 64'h15c7b798338d996e,
    64'hd7983aadcc82db47, 64'h9fa856de92b52c0d
  };

  localparam logic [LaneWidth-1:0] XKey0 = {64'h0689020190dc56bf, 64'h8b24949ff6fa8389};
  localparam logic [LaneWidth-1:0] XKey1 = {64'hed18f99bee1043c6, 64'h51f4e03c61b263d1};

  localparam logic [7:0] SBox [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  localparam logic [7:0] InvSBox [256] = '{
    8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
    8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
    8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
    8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
    8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
    8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
    8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
    8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
    8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
    8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
    8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
    8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
    8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
    8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
    8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
    8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
    8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
    8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
    8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
    8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
    8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
    8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
    8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
    8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
    8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
    8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
    8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
    8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
    8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
    8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
    8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
    8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
  };

  // gf(2^8) products by the mix-column constants
  function automatic logic [7:0] gf_x2(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_x3(input logic [7:0] a);
    return gf_x2(a) ^ a;
  endfunction

  function automatic logic [7:0] gf_x9(input logic [7:0] a);
    return gf_x2(gf_x2(gf_x2(a))) ^ a;
  endfunction

  function automatic logic [7:0] gf_x11(input logic [7:0] a);
    return gf_x2(gf_x2(gf_x2(a))) ^ gf_x2(a) ^ a;
  endfunction

  function automatic logic [7:0] gf_x13(input logic [7:0] a);
    return gf_x2(gf_x2(gf_x2(a))) ^ gf_x2(gf_x2(a)) ^ a;
  endfunction

  function automatic logic [7:0] gf_x14(input logic [7:0] a);
    return gf_x2(gf_x2(gf_x2(a))) ^ gf_x2(gf_x2(a)) ^ gf_x2(a);
  endfunction

endpackage

// ----- src/aes_four_lane_hash.sv -----
// a last item's hash is registered in fin1, then fin2, then the output register on m_tdata
// throughput: one 64-byte item per cycle while s_tready is high; each lane does one aes round
//   per item; the two finishing rounds run in their own pipeline stages behind the lane state
// s_tready drops only when the finishing pipeline is full and the output is stalled
// reset (rst, synchronous): lane state reloads the initial constants, pipeline emptied
module aes_four_lane_hash (
  input  logic                            clk,
  input  logic                            rst,
  // input items
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [aesh_pkg::BlockWidth-1:0] s_tdata,  // block_word0 .. block_word7, 64 bits each
  input  logic                            s_tlast,  // last_block
  // result items
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [aesh_pkg::BlockWidth-1:0] m_tdata   // hash_word0 .. hash_word7, 64 bits each
);

  localparam int unsigned BW = aesh_pkg::BlockWidth;

  // running lane state and the absorb round
  logic [BW-1:0] lane_state;
  logic [BW-1:0] absorbed;

  // finishing pipeline: fin1 holds absorbed state of a last item, fin2 after the xkey0 round
  logic          fin1_valid;
  logic [BW-1:0] fin1;
  logic          fin2_valid;
  logic [BW-1:0] fin2;
  logic [BW-1:0] fin2_next;
  logic [BW-1:0] hash_next;

  logic out_ready;
  logic fin2_ready;
  logic fin1_ready;
  logic accept;

  // stage advances whenever the stage below has room
  assign out_ready  = !m_tvalid || m_tready;
  assign fin2_ready = !fin2_valid || out_ready;
  assign fin1_ready = !fin1_valid || fin2_ready;
  assign s_tready   = fin1_ready;
  assign accept     = s_tvalid && s_tready;

  // absorb: block words are the per-lane round keys
  aesh_lane_group u_absorb (
    .state_in  (lane_state),
    .keys      (s_tdata),
    .state_out (absorbed)
  );

  // first finishing round, same key in every lane
  aesh_lane_group u_fin_xkey0 (
    .state_in  (fin1),
    .keys      ({aesh_pkg::LaneCount{aesh_pkg::XKey0}}),
    .state_out (fin2_next)
  );

  // second finishing round feeds the output register
  aesh_lane_group u_fin_xkey1 (
    .state_in  (fin2),
    .keys      ({aesh_pkg::LaneCount{aesh_pkg::XKey1}}),
    .state_out (hash_next)
  );

  // lane state: a last item hands its state down the pipe and the lanes start afresh
  always_ff @(posedge clk) begin
    if (rst) begin
      lane_state <= aesh_pkg::InitState;
    end else if (accept) begin
      lane_state <= s_tlast ? aesh_pkg::InitState : absorbed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin1_valid <= 1'b0;
    end else if (accept && s_tlast) begin
      fin1_valid <= 1'b1;
    end else if (fin2_ready) begin
      fin1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && s_tlast) begin
      fin1 <= absorbed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin2_valid <= 1'b0;
    end else if (fin2_ready) begin
      fin2_valid <= fin1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fin2_ready) begin
      fin2 <= fin2_next;
    end
  end

  // output register: lanes merged into one 512-bit hash item
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_tvalid <= fin2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) begin
      m_tdata <= hash_next;
    end
  end

  // a last item always restarts the lanes from the initial constants
  a_restart: assert property (@(posedge clk) disable iff (rst)
    accept && s_tlast |=> lane_state == aesh_pkg::InitState)
    else $error("lane state not reloaded after last item");

  // a last item always lands in the first finishing stage
  a_fin1_load: assert property (@(posedge clk) disable iff (rst)
    accept && s_tlast |=> fin1_valid)
    else $error("last item lost before finishing rounds");

  // a stalled finishing stage keeps its contents
  a_fin1_hold: assert property (@(posedge clk) disable iff (rst)
    fin1_valid && !fin2_ready |=> fin1_valid && $stable(fin1))
    else $error("finishing stage overwritten while stalled");

  // a new result only ever comes out of the second finishing stage
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(fin2_valid))
    else $error("result item without a finished hash behind it");

endmodule

// ----- src/aesh_round.sv -----
// one aes round on a 128-bit lane: encrypt or decrypt form
module aesh_round #(
  parameter bit Decrypt = 1'b0
) (
  input  logic [aesh_pkg::LaneWidth-1:0] lane_in,
  input  logic [aesh_pkg::LaneWidth-1:0] round_key,
  output logic [aesh_pkg::LaneWidth-1:0] lane_out
);

  logic [7:0] subbed [16];
  logic [7:0] mixed  [16];

  // (inv)shiftrows folded into the byte pick, then (inv)subbytes
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (Decrypt) begin
          subbed[c*4+r] = aesh_pkg::InvSBox[lane_in[(((c+4-r)%4)*4+r)*8 +: 8]];
        end else begin
          subbed[c*4+r] = aesh_pkg::SBox[lane_in[(((c+r)%4)*4+r)*8 +: 8]];
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      if (Decrypt) begin
        mixed[c*4]   = aesh_pkg::gf_x14(subbed[c*4]) ^ aesh_pkg::gf_x11(subbed[c*4+1])
                     ^ aesh_pkg::gf_x13(subbed[c*4+2]) ^ aesh_pkg::gf_x9(subbed[c*4+3]);
        mixed[c*4+1] = aesh_pkg::gf_x9(subbed[c*4]) ^ aesh_pkg::gf_x14(subbed[c*4+1])
                     ^ aesh_pkg::gf_x11(subbed[c*4+2]) ^ aesh_pkg::gf_x13(subbed[c*4+3]);
        mixed[c*4+2] = aesh_pkg::gf_x13(subbed[c*4]) ^ aesh_pkg::gf_x9(subbed[c*4+1])
                     ^ aesh_pkg::gf_x14(subbed[c*4+2]) ^ aesh_pkg::gf_x11(subbed[c*4+3]);
        mixed[c*4+3] = aesh_pkg::gf_x11(subbed[c*4]) ^ aesh_pkg::gf_x13(subbed[c*4+1])
                     ^ aesh_pkg::gf_x9(subbed[c*4+2]) ^ aesh_pkg::gf_x14(subbed[c*4+3]);
      end else begin
        mixed[c*4]   = aesh_pkg::gf_x2(subbed[c*4]) ^ aesh_pkg::gf_x3(subbed[c*4+1])
                     ^ subbed[c*4+2] ^ subbed[c*4+3];
        mixed[c*4+1] = subbed[c*4] ^ aesh_pkg::gf_x2(subbed[c*4+1])
                     ^ aesh_pkg::gf_x3(subbed[c*4+2]) ^ subbed[c*4+3];
        mixed[c*4+2] = subbed[c*4] ^ subbed[c*4+1]
                     ^ aesh_pkg::gf_x2(subbed[c*4+2]) ^ aesh_pkg::gf_x3(subbed[c*4+3]);
        mixed[c*4+3] = aesh_pkg::gf_x3(subbed[c*4]) ^ subbed[c*4+1]
                     ^ subbed[c*4+2] ^ aesh_pkg::gf_x2(subbed[c*4+3]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      lane_out[i*8 +: 8] = mixed[i] ^ round_key[i*8 +: 8];
    end
  end

endmodule

// ----- src/aesh_lane_group.sv -----
// four lanes side by side: even lanes encrypt, odd lanes decrypt
module aesh_lane_group (
  input  logic [aesh_pkg::BlockWidth-1:0] state_in,
  input  logic [aesh_pkg::BlockWidth-1:0] keys,
  output logic [aesh_pkg::BlockWidth-1:0] state_out
);

  localparam int unsigned LW = aesh_pkg::LaneWidth;

  for (genvar l = 0; l < aesh_pkg::LaneCount; l++) begin : g_lane
    aesh_round #(
      .Decrypt ((l % 2) == 1)
    ) u_round (
      .lane_in   (state_in[l*LW +: LW]),
      .round_key (keys[l*LW +: LW]),
      .lane_out  (state_out[l*LW +: LW])
    );
  end

endmodule

// ----- test/aes_four_lane_hash_tb.sv -----
module aes_four_lane_hash_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BlockWidth = aesh_pkg::BlockWidth;

  // lanes 0 and 2 take the forward round, lanes 1 and 3 the inverse one
  typedef enum logic {RoundEnc, RoundDec} round_kind_t;

  // seed state and finishing keys, lane i in bits [128i +: 128]
  localparam logic [BlockWidth-1:0] LaneSeed = {
    64'h7e99494879a10005, 64'h07ad828d630a240c,
    64'he8a07ce45079506b, 64'hae62c7d06a770017,
    64'hace78057f59e125a, 64'h15c7b798338d996e,
    64'hd7983aadcc82db47, 64'h9fa856de92b52c0d
  };
  localparam logic [127:0] FinishKey0 = {64'h0689020190dc56bf, 64'h8b24949ff6fa8389};
  localparam logic [127:0] FinishKey1 = {64'hed18f99bee1043c6, 64'h51f4e03c61b263d1};

  localparam int DirCount   = 14;
  localparam int RandBlocks = 1636;
  localparam int CalmTail   = 150;     // no idling or stalls over the last blocks
  localparam int CycleLimit = 300000;
  localparam int PrintLimit = 40;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [BlockWidth-1:0] s_tdata = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [BlockWidth-1:0] m_tdata;

  aes_four_lane_hash u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state: s-boxes derived from the field inverse, running lane state
  logic [7:0]            sub_fwd [256];
  logic [7:0]            sub_inv [256];
  logic [BlockWidth-1:0] hash_lanes = LaneSeed;
  logic [BlockWidth-1:0] pending_hashes [$];

  int  error_count = 0;
  int  blocks_taken = 0;
  int  hashes_seen = 0;
  int  messages_sent = 0;
  int  cycle_count = 0;
  bit  jitter_on = 1'b1;

  // directed stimulus: block data and the last flag of each row
  logic [BlockWidth-1:0] dir_data [DirCount] = '{
    {8{64'h0000000000000000}},                          // single block of zeros
    {8{64'hffffffffffffffff}},                          // single block of ones
    {8{64'h0000000000000001}},                          // three-block message starts
    {8{64'hffffffffffffffff}},
    {8{64'h0000000000000000}},
    {8{64'haaaaaaaaaaaaaaaa}},                          // back-to-back single blocks
    {8{64'h5555555555555555}},
    {64'h8000000000000000, {6{64'h0}}, 64'h1},          // top and bottom bits only
    {4{128'h0f0e0d0c0b0a09080706050403020100}},         // byte index per lane
    LaneSeed,                                           // key equal to the seed state
    {{4{64'hffffffff00000000}}, {4{64'h00000000ffffffff}}},
    {8{64'h0000000000000000}},                          // three-block message of extremes
    {8{64'h0000000000000000}},
    {8{64'hffffffffffffffff}}
  };
  localparam logic [DirCount-1:0] DirLast = 14'b10_0110_0111_0011;

  // ---------------------------------------------------------------- predictor

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] p;
    acc = 8'h00;
    p = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= p;
      p = {p[6:0], 1'b0} ^ (p[7] ? 8'h1b : 8'h00);
    end
    return acc;
  endfunction

  // s-box = affine map of the multiplicative inverse
  function automatic void make_sboxes();
    logic [7:0] inv;
    logic [7:0] s;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h00;
      if (x != 0)
        for (int y = 1; y < 256; y++)
          if (gf_mul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
      s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      sub_fwd[x] = s;
      sub_inv[s] = x[7:0];
    end
  endfunction

  // one round on a lane: (inv)shiftrows, (inv)subbytes, (inv)mixcolumns, key xor
  function automatic logic [127:0] lane_round(input logic [127:0] st, input logic [127:0] key,
                                              input round_kind_t kind);
    logic [7:0]   a [16];
    logic [7:0]   t [16];
    logic [7:0]   b0, b1, b2, b3;
    logic [127:0] res;
    int           src;
    for (int i = 0; i < 16; i++) a[i] = st[8*i +: 8];
    for (int c = 0; c < 4; c++)
      for (int rw = 0; rw < 4; rw++) begin
        if (kind == RoundDec) begin
          src = (c + 4 - rw) % 4;
          t[c*4+rw] = sub_inv[a[src*4+rw]];
        end else begin
          src = (c + rw) % 4;
          t[c*4+rw] = sub_fwd[a[src*4+rw]];
        end
      end
    for (int c = 0; c < 4; c++) begin
      b0 = t[c*4];
      b1 = t[c*4+1];
      b2 = t[c*4+2];
      b3 = t[c*4+3];
      if (kind == RoundDec) begin
        res[8*(c*4)   +: 8] = gf_mul(b0, 8'd14) ^ gf_mul(b1, 8'd11) ^ gf_mul(b2, 8'd13)
                            ^ gf_mul(b3, 8'd9);
        res[8*(c*4+1) +: 8] = gf_mul(b0, 8'd9) ^ gf_mul(b1, 8'd14) ^ gf_mul(b2, 8'd11)
                            ^ gf_mul(b3, 8'd13);
        res[8*(c*4+2) +: 8] = gf_mul(b0, 8'd13) ^ gf_mul(b1, 8'd9) ^ gf_mul(b2, 8'd14)
                            ^ gf_mul(b3, 8'd11);
        res[8*(c*4+3) +: 8] = gf_mul(b0, 8'd11) ^ gf_mul(b1, 8'd13) ^ gf_mul(b2, 8'd9)
                            ^ gf_mul(b3, 8'd14);
      end else begin
        res[8*(c*4)   +: 8] = gf_mul(b0, 8'd2) ^ gf_mul(b1, 8'd3) ^ b2 ^ b3;
        res[8*(c*4+1) +: 8] = b0 ^ gf_mul(b1, 8'd2) ^ gf_mul(b2, 8'd3) ^ b3;
        res[8*(c*4+2) +: 8] = b0 ^ b1 ^ gf_mul(b2, 8'd2) ^ gf_mul(b3, 8'd3);
        res[8*(c*4+3) +: 8] = gf_mul(b0, 8'd3) ^ b1 ^ b2 ^ gf_mul(b3, 8'd2);
      end
    end
    return res ^ key;
  endfunction

  function automatic logic [BlockWidth-1:0] round_all(input logic [BlockWidth-1:0] st,
                                                      input logic [BlockWidth-1:0] keys);
    logic [BlockWidth-1:0] nxt;
    for (int l = 0; l < 4; l++)
      nxt[128*l +: 128] = lane_round(st[128*l +: 128], keys[128*l +: 128],
                                     (l % 2 == 1) ? RoundDec : RoundEnc);
    return nxt;
  endfunction

  // absorb one block; on the last one finish, hand out the digest and reseed
  function automatic bit absorb_block(input logic [BlockWidth-1:0] blk, input logic last,
                                      output logic [BlockWidth-1:0] digest);
    hash_lanes = round_all(hash_lanes, blk);
    digest = '0;
    if (!last) return 1'b0;
    hash_lanes = round_all(hash_lanes, {4{FinishKey0}});
    hash_lanes = round_all(hash_lanes, {4{FinishKey1}});
    digest = hash_lanes;
    hash_lanes = LaneSeed;
    return 1'b1;
  endfunction

  initial make_sboxes();

  // ------------------------------------------------------------------ checking

  task automatic report_error(input string what);
    error_count++;
    if (error_count <= PrintLimit) $display("ERROR at %0t: %s", $time, what);
  endtask

  // both sides sampled at the rising edge, values settled since the falling edge
  always @(posedge clk) begin
    logic [BlockWidth-1:0] digest;
    logic [BlockWidth-1:0] want;
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d hashes outstanding", cycle_count,
               pending_hashes.size());
      $display("aes_four_lane_hash regression: fail");
      $finish;
    end
    if (rst) begin
      hash_lanes = LaneSeed;
    end else begin
      if (m_tvalid && m_tready) begin
        hashes_seen++;
        if (pending_hashes.size() == 0) begin
          report_error($sformatf("unexpected hash %h", m_tdata));
        end else begin
          want = pending_hashes.pop_front();
          for (int w = 0; w < 8; w++)
            if (m_tdata[64*w +: 64] !== want[64*w +: 64])
              report_error($sformatf("hash %0d hash_word%0d got %h want %h", hashes_seen, w,
                                     m_tdata[64*w +: 64], want[64*w +: 64]));
        end
      end
      if (s_tvalid && s_tready) begin
        blocks_taken++;
        if (absorb_block(s_tdata, s_tlast, digest)) pending_hashes.push_back(digest);
      end
    end
  end

  // ------------------------------------------------------------------ driving

  // output side: random stall bursts while jitter is on
  initial begin
    @(negedge clk);
    forever begin
      @(negedge clk);
      if (jitter_on && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  // called at a falling edge; returns at the falling edge after the item is taken
  task automatic send_block(input logic [BlockWidth-1:0] blk, input logic last);
    int taken;
    if (jitter_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= {16{$urandom}};
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    taken = blocks_taken;
    s_tvalid <= 1'b1;
    s_tdata  <= blk;
    s_tlast  <= last;
    if (last) messages_sent++;
    do @(negedge clk); while (blocks_taken == taken);
  endtask

  function automatic logic [63:0] rand_word();
    unique case ($urandom_range(0, 19))
      0:       return 64'h0000000000000000;
      1:       return 64'hffffffffffffffff;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // mostly short messages, now and then a long one
  function automatic int rand_msg_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) return $urandom_range(1, 6);
    if (pick < 95) return $urandom_range(7, 20);
    return $urandom_range(21, 60);
  endfunction

  task automatic drain_hashes();
    s_tvalid <= 1'b0;
    while (pending_hashes.size() != 0) @(negedge clk);
  endtask

  initial begin
    logic [BlockWidth-1:0] blk;
    int                    len;
    int                    sent;
    bit                    paused;
    sent = 0;
    paused = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed rows
    for (int i = 0; i < DirCount; i++) send_block(dir_data[i], DirLast[i]);
    // hold the sender off until every hash is back
    drain_hashes();
    @(negedge clk);

    // random messages
    while (sent < RandBlocks) begin
      len = rand_msg_len();
      if (len > RandBlocks - sent) len = RandBlocks - sent;
      for (int k = 0; k < len; k++) begin
        if (sent >= RandBlocks - CalmTail) jitter_on = 1'b0;
        for (int w = 0; w < 8; w++) blk[64*w +: 64] = rand_word();
        send_block(blk, k == len - 1);
        sent++;
      end
      // one more full pause half way through, between messages
      if (!paused && sent >= RandBlocks / 2) begin
        paused = 1'b1;
        drain_hashes();
        @(negedge clk);
      end
    end
    s_tvalid <= 1'b0;

    // wait out the last hashes plus the pipeline depth
    while (pending_hashes.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("%0d blocks in %0d messages hashed, %0d hashes compared word by word",
             blocks_taken, messages_sent, hashes_seen);
    $display("%0d mismatches", error_count);
    if (error_count == 0) begin
      $display("aes_four_lane_hash regression: pass");
    end else begin
      $display("aes_four_lane_hash regression: fail");
    end
    $finish;
  end

endmodule
